FILE: design/gpsm_pkg.sv
// ----------------------------------------------------------------------------
// gpsm_pkg: shared types and constants for the square-and-multiply block
// Control handshake structs between controller and datapath, state encoding
// and the chunk size of the shared multiplier.
// ----------------------------------------------------------------------------
package gpsm_pkg;

	// default operand width
	localparam int DATA_WIDTH_DEF = 32;

	// multiplier works on chunks of this many bits per cycle
	localparam int CHUNK_LOG = 5;
	localparam int CHUNK_W   = 1 << CHUNK_LOG;

	// operation mode register values
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_MUL = 1'b1;

	// which register the shared operator writes
	typedef enum logic {
		SEL_COMB = 1'b0, // acc = acc op a
		SEL_SQR  = 1'b1  // a = a op a
	} op_sel_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_AFTER,
		ST_MUL_COMB,
		ST_MUL_SQR,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;    // take a new input transfer
		logic    start;   // begin an operation (first partial product)
		logic    cont;    // continue an operation (further partial products)
		logic    shift;   // shift the exponent count right by one
		logic    capture; // move the finished value to the output register
		op_sel_t sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;    // exponent count is zero
		logic cnt_b0;      // low bit of exponent count
		logic cnt_hi_zero; // count shifted right by one is zero
		logic err;         // zero base with negative exponent in multiply mode
		logic last_start;  // an operation finishes in its start cycle
		logic last_cont;   // the current continuation cycle is the last one
	} dp_status_t;

endpackage

FILE: design/gpsm_dpath.sv
// ----------------------------------------------------------------------------
// gpsm_dpath: datapath of the square-and-multiply block
// Holds base, accumulator and exponent count, the shared add/multiply
// operator (chunked for wide operands), the mode register and the result.
// ----------------------------------------------------------------------------
module gpsm_dpath #(
	parameter int DATA_WIDTH = gpsm_pkg::DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic [DATA_WIDTH-1:0]  base,
	input  logic [DATA_WIDTH-1:0]  exponent,
	input  gpsm_pkg::dp_cmd_t      cmd,
	output gpsm_pkg::dp_status_t   st,
	output logic [DATA_WIDTH-1:0]  result,
	output logic                   divide_error
);
	import gpsm_pkg::*;

	localparam int NCH = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;
	localparam int EW  = NCH * CHUNK_W;
	localparam int PW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int WW  = EW + 2 * CHUNK_W;

	logic                  op_mode_q;
	logic [DATA_WIDTH-1:0] a_q, acc_q, cnt_q, sum_q, res_q;
	logic                  err_q, res_err_q;
	logic [PW-1:0]         pi_q, pj_q;

	logic                  neg, base_zero, base_unit;
	logic [DATA_WIDTH-1:0] mag, a_ld, acc_ld;
	logic                  err_ld;

	logic [DATA_WIDTH-1:0] x, y, psum, addv, opv;
	logic [EW-1:0]         xe, ye;
	logic [CHUNK_W-1:0]    xc, yc;
	logic [2*CHUNK_W-1:0]  prod;
	logic [WW-1:0]         pwide;
	logic [PW-1:0]         cur_i, cur_j, nxt_i, nxt_j;
	logic [PW:0]           ij;
	logic [PW+CHUNK_LOG:0] shamt;
	logic                  last_cur, busy;

	// input preparation: magnitude of exponent and inverse of base
	always_comb begin
		neg       = exponent[DATA_WIDTH-1];
		mag       = neg ? (DATA_WIDTH'(0) - exponent) : exponent;
		base_zero = (base == '0);
		base_unit = (base == DATA_WIDTH'(1)) || (&base);
		err_ld    = neg && (op_mode_q == MODE_MUL) && base_zero;
		acc_ld    = (op_mode_q == MODE_MUL) ? DATA_WIDTH'(1) : '0;
		if (!neg) begin
			a_ld = base;
		end else if (op_mode_q == MODE_ADD) begin
			a_ld = DATA_WIDTH'(0) - base;
		end else if (base_unit) begin
			a_ld = base;
		end else begin
			a_ld = '0;
		end
	end

	// shared operator: in multiply mode one chunk product plus running sum per cycle, in add mode a plain sum
	always_comb begin
		x     = (cmd.sel == SEL_COMB) ? acc_q : a_q;
		y     = a_q;
		cur_i = cmd.start ? '0 : pi_q;
		cur_j = cmd.start ? '0 : pj_q;
		xe    = EW'(x);
		ye    = EW'(y);
		xc    = xe[cur_i*CHUNK_W +: CHUNK_W];
		yc    = ye[cur_j*CHUNK_W +: CHUNK_W];
		prod  = xc * yc;
		ij    = {1'b0, cur_i} + {1'b0, cur_j};
		shamt = {ij, {CHUNK_LOG{1'b0}}};
		pwide = WW'(prod) << shamt;
		psum  = (cmd.start ? '0 : sum_q) + pwide[DATA_WIDTH-1:0];
		addv  = x + y;
		opv   = (op_mode_q == MODE_MUL) ? psum : addv;
		// next chunk pair, walking only pairs that land below the word width
		if (ij == (PW+1)'(NCH - 1)) begin
			nxt_i = cur_i + PW'(1);
			nxt_j = '0;
		end else begin
			nxt_i = cur_i;
			nxt_j = cur_j + PW'(1);
		end
	end

	// status back to controller
	always_comb begin
		st.cnt_zero    = (cnt_q == '0);
		st.cnt_b0      = cnt_q[0];
		st.cnt_hi_zero = (cnt_q[DATA_WIDTH-1:1] == '0);
		st.err         = err_q;
		st.last_start  = (op_mode_q == MODE_ADD) || (NCH == 1);
		st.last_cont   = (op_mode_q == MODE_ADD) ||
			((pi_q == PW'(NCH - 1)) && (pj_q == '0));
		last_cur       = cmd.start ? st.last_start : st.last_cont;
		busy           = cmd.start || cmd.cont;
	end

	// mode register and chunk pair counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= MODE_MUL;
			pi_q      <= '0;
			pj_q      <= '0;
		end else begin
			if (cfg_we) begin
				op_mode_q <= cfg_wdata;
			end
			if (busy) begin
				pi_q <= nxt_i;
				pj_q <= nxt_j;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= a_ld;
			acc_q <= acc_ld;
			cnt_q <= mag;
			err_q <= err_ld;
		end else begin
			if (cmd.shift) begin
				cnt_q <= cnt_q >> 1;
			end
			if (busy) begin
				if (!last_cur) begin
					sum_q <= psum;
				end else if (cmd.sel == SEL_COMB) begin
					acc_q <= opv;
				end else begin
					a_q <= opv;
				end
			end
		end
		if (cmd.capture) begin
			res_q     <= err_q ? '0 : acc_q;
			res_err_q <= err_q;
		end
	end

	assign result       = res_q;
	assign divide_error = res_err_q;

endmodule

FILE: design/gpsm_ctrl.sv
// ----------------------------------------------------------------------------
// gpsm_ctrl: controller of the square-and-multiply block
// Walks the exponent bits, issues combine and square operations to the
// datapath and owns both stream handshakes.
// ----------------------------------------------------------------------------
module gpsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  gpsm_pkg::dp_status_t  st,
	output gpsm_pkg::dp_cmd_t     cmd
);
	import gpsm_pkg::*;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		out_free    = !m_tvalid_q || m_tready;
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.start   = 1'b0;
		cmd.cont    = 1'b0;
		cmd.shift   = 1'b0;
		cmd.capture = 1'b0;
		cmd.sel     = SEL_COMB;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			// look at the low exponent bit
			ST_TEST: begin
				if (st.err || st.cnt_zero) begin
					state_d = ST_FINISH;
				end else if (st.cnt_b0) begin
					cmd.start = 1'b1;
					cmd.sel   = SEL_COMB;
					state_d   = st.last_start ? ST_AFTER : ST_MUL_COMB;
				end else begin
					cmd.start = 1'b1;
					cmd.shift = 1'b1;
					cmd.sel   = SEL_SQR;
					state_d   = st.last_start ? ST_TEST : ST_MUL_SQR;
				end
			end
			// combine done, square only if bits remain
			ST_AFTER: begin
				if (st.cnt_hi_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.start = 1'b1;
					cmd.shift = 1'b1;
					cmd.sel   = SEL_SQR;
					state_d   = st.last_start ? ST_TEST : ST_MUL_SQR;
				end
			end
			ST_MUL_COMB: begin
				cmd.cont = 1'b1;
				cmd.sel  = SEL_COMB;
				if (st.last_cont) begin
					state_d = ST_AFTER;
				end
			end
			ST_MUL_SQR: begin
				cmd.cont = 1'b1;
				cmd.sel  = SEL_SQR;
				if (st.last_cont) begin
					state_d = ST_TEST;
				end
			end
			// wait for the output register to free up
			ST_FINISH: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: design/generic_power_square_multiply_top.sv
// ----------------------------------------------------------------------------
// generic_power_square_multiply_top: power of a base by square-and-multiply
// Combines a signed base with itself |exponent| times under add or multiply,
// modulo 2^DATA_WIDTH, with inverse handling for negative exponents.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                 | contents
//  ---------+-----------+-------------------------+---------------------------
//  s_*      | in        | tvalid tready tdata     | base, exponent
//  m_*      | out       | tvalid tready tdata tuser | result, divide_error
//  cfg_*    | in        | we wdata                | op_mode
//
//  The load, then per exponent bit one square and, for a set bit, one
//  combine on the shared operator (the top bit needs no square), then the
//  capture into the output register. Above 32 bits each multiply walks the
//  32-bit chunk pairs whose product lands below the word width.
//  A new transfer is taken once the previous result is in the output register.
//  Reset selects multiply mode; a stalled output holds the result in place.
// ----------------------------------------------------------------------------
module generic_power_square_multiply_top #(
	parameter int DATA_WIDTH = gpsm_pkg::DATA_WIDTH_DEF,
	localparam int IN_TW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // base, exponent
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,  // result
	output logic              m_tuser,  // divide_error
	input  logic              cfg_we,
	input  logic              cfg_wdata // op_mode
);
	import gpsm_pkg::*;

	dp_cmd_t               cmd;
	dp_status_t            st;
	logic [DATA_WIDTH-1:0] result;

	// sequencer
	gpsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// registers and shared operator
	gpsm_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.base         (s_tdata[DATA_WIDTH-1:0]),
		.exponent     (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.cmd          (cmd),
		.st           (st),
		.result       (result),
		.divide_error (m_tuser)
	);

	// zero padded output word
	assign m_tdata = OUT_TW'(result);

endmodule

FILE: design/gpsm_checker.sv
// ----------------------------------------------------------------------------
// gpsm_checker: port level checks for the square-and-multiply block
// Watches the stream ports and flags handshake or result slips.
// ----------------------------------------------------------------------------
module gpsm_checker #(
	parameter int DATA_WIDTH = gpsm_pkg::DATA_WIDTH_DEF,
	localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata,
	input logic              m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	// a divide error always carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("divide error with nonzero result");

	// one item at a time: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// a result cannot appear in the cycle right after a transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind generic_power_square_multiply_top gpsm_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_gpsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for generic_power_square_multiply_top
// Streams base/exponent pairs in add and multiply mode, predicts each power
// in a scoreboard and compares every returned transfer field by field, with
// random bursts on the input and a changing stall pattern on the output.
// ----------------------------------------------------------------------------

// expected powers of accepted operand pairs, checked in order
class power_scoreboard;
	typedef logic [gpsm_pkg::DATA_WIDTH_DEF-1:0] word_t;
	typedef struct {
		word_t result;
		logic  divide_error;
	} power_t;

	power_t pending_powers[$];
	logic   op_mode;
	int     mismatch_count;
	int     checked_count;

	function new();
		op_mode        = gpsm_pkg::MODE_MUL;
		mismatch_count = 0;
		checked_count  = 0;
	endfunction

	function void set_mode(logic mode);
		op_mode = mode;
	endfunction

	function int pending_count();
		return pending_powers.size();
	endfunction

	// square-and-multiply over the exponent magnitude
	function void note_operands(word_t base_v, word_t exp_v);
		word_t  a;
		word_t  cnt;
		word_t  acc;
		logic   err;
		power_t p;
		int     i;
		a   = base_v;
		cnt = exp_v;
		err = 1'b0;
		// negative count: use the inverse of the base
		if (exp_v[$bits(word_t)-1]) begin
			cnt = '0 - exp_v;
			if (op_mode == gpsm_pkg::MODE_ADD) begin
				a = '0 - base_v;
			end else if (base_v == '0) begin
				err = 1'b1;
			end else if (base_v != word_t'(1) && base_v != '1) begin
				a = '0;
			end
		end
		acc = (op_mode == gpsm_pkg::MODE_MUL) ? word_t'(1) : '0;
		if (err) begin
			acc = '0;
		end else begin
			for (i = 0; i < $bits(word_t); i++) begin
				if (cnt[i])
					acc = (op_mode == gpsm_pkg::MODE_MUL) ? acc * a : acc + a;
				a = (op_mode == gpsm_pkg::MODE_MUL) ? a * a : a + a;
			end
		end
		p.result       = acc;
		p.divide_error = err;
		pending_powers.push_back(p);
	endfunction

	function void check_power(word_t result, logic divide_error);
		power_t p;
		if (pending_powers.size() == 0) begin
			$error("result transfer with nothing pending: result %h divide_error %b",
				result, divide_error);
			mismatch_count++;
			return;
		end
		p = pending_powers.pop_front();
		checked_count++;
		if (result !== p.result) begin
			$error("result: expected %h, got %h", p.result, result);
			mismatch_count++;
		end
		if (divide_error !== p.divide_error) begin
			$error("divide_error: expected %b, got %b", p.divide_error, divide_error);
			mismatch_count++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW          = gpsm_pkg::DATA_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_WAIT  = 2 * DW + 16;
	localparam int RANDOM_PER_PHASE = 275;

	localparam logic [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] W_M1  = '1;

	// output stall patterns
	typedef enum int {
		READY_ALWAYS,
		READY_RANDOM,
		READY_SPARSE,
		READY_BLOCKED
	} stall_kind_t;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [2*DW-1:0] s_tdata;  // base, exponent
	logic            m_tvalid;
	logic            m_tready;
	logic [DW-1:0]   m_tdata;  // result
	logic            m_tuser;  // divide_error
	logic            cfg_we;
	logic            cfg_wdata; // op_mode

	power_scoreboard sb;
	int              burst_left;
	int              sent_count;
	int              mode_writes;
	int              cycle_count;
	stall_kind_t     stall_kind;
	int              stall_left;

	generic_power_square_multiply_top #(
		.DATA_WIDTH(DW)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	// input transfers feed the prediction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_operands(s_tdata[DW-1:0], s_tdata[2*DW-1:DW]);
	end

	// output transfers are checked in order
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_power(m_tdata, m_tuser);
	end

	// receiver stall pattern, picked anew at random each time the current one runs out
	initial begin
		stall_kind = READY_ALWAYS;
		stall_left = 0;
	end
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_kind = stall_kind_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_kind)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			READY_SPARSE: m_tready <= (stall_left % 5 == 0);
			default: m_tready <= (stall_left < 2);
		endcase
	end

	// one operand pair, held until transferred; bursts separated by gaps
	task automatic drive_item(logic [DW-1:0] base_v, logic [DW-1:0] exp_v);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {exp_v, base_v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		sent_count++;
	endtask

	// stop sending and wait for every pending result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_count() != 0);
	endtask

	// mode change only while nothing is in flight
	task automatic write_mode(logic mode);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_mode(mode);
		mode_writes++;
	endtask

	function automatic logic [DW-1:0] random_base();
		logic [DW-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom();
			2: v = DW'($urandom_range(0, 8)) - DW'(4);
			3: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = DW'(1);
					2: v = W_M1;
					3: v = W_MIN;
					default: v = W_MAX;
				endcase
			end
			4: begin
				v = DW'(1) << $urandom_range(0, DW - 1);
				if ($urandom_range(0, 1))
					v = '0 - v;
			end
			default: v = $urandom() >> $urandom_range(0, DW - 1);
		endcase
		return v;
	endfunction

	function automatic logic [DW-1:0] random_exponent();
		logic [DW-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom();
			1: v = DW'($urandom_range(0, 80)) - DW'(40);
			2: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = DW'(1);
					2: v = W_M1;
					3: v = W_MIN;
					4: v = W_MAX;
					default: v = W_MIN + DW'(1);
				endcase
			end
			3: v = W_MIN | DW'($urandom());
			default: v = DW'(1) << $urandom_range(0, DW - 1);
		endcase
		return v;
	endfunction

	task automatic random_phase(int count);
		int i;
		for (i = 0; i < count; i++) begin
			// at least once mid-phase, let the block run dry
			if (i == count / 3)
				wait_drained();
			drive_item(random_base(), random_exponent());
		end
	endtask

	// stimulus and end of run
	initial begin
		sb          = new();
		burst_left  = 0;
		sent_count  = 0;
		mode_writes = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// multiply mode out of reset
		drive_item(DW'(2), DW'(10));
		drive_item(DW'(3), W_M1);
		drive_item('0, DW'(-5));
		drive_item('0, W_MIN);
		drive_item(DW'(1), W_MIN);
		drive_item(W_M1, W_MIN);
		drive_item(W_M1, W_MAX);
		drive_item(W_M1, DW'(-3));
		drive_item(W_MAX, W_MAX);
		drive_item(W_MIN, DW'(2));
		drive_item('0, '0);
		drive_item(DW'(7), '0);

		// add mode
		write_mode(gpsm_pkg::MODE_ADD);
		drive_item(DW'(5), DW'(-3));
		drive_item(W_MIN, W_M1);
		drive_item(W_MAX, W_MAX);
		drive_item('0, W_MIN);
		drive_item(DW'(1), W_MIN);
		drive_item(W_M1, W_MAX);
		drive_item(DW'(3), '0);
		drive_item('0, DW'(-7));
		drive_item(W_MIN, W_MIN);
		drive_item(W_M1, W_M1);
		drive_item(W_MAX, DW'(1));
		drive_item(DW'(-9), DW'(37));

		// random phases with alternating modes
		write_mode(gpsm_pkg::MODE_MUL);
		random_phase(RANDOM_PER_PHASE);
		write_mode(gpsm_pkg::MODE_ADD);
		random_phase(RANDOM_PER_PHASE);
		write_mode(gpsm_pkg::MODE_MUL);
		random_phase(RANDOM_PER_PHASE);
		write_mode(gpsm_pkg::MODE_ADD);
		random_phase(RANDOM_PER_PHASE);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d operand pairs across %0d mode writes (add and multiply)",
			sent_count, mode_writes);
		$display("checked %0d results, %0d mismatches",
			sb.checked_count, sb.mismatch_count);
		if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
